@@ design/dlc_pkg.sv @@
// Shared types and constants for the device lifecycle controller.
// Holds the lifecycle state, event code and LED pattern encodings.
// No dependencies.
package dlc_pkg;

  typedef enum logic [3:0] {
    ST_BOOT     = 4'd0,
    ST_SELFTEST = 4'd1,
    ST_UNPROV   = 4'd2,
    ST_PAIRING  = 4'd3,
    ST_WIFIPROV = 4'd4,
    ST_LORA     = 4'd5,
    ST_READY    = 4'd6,
    ST_OTA      = 4'd7,
    ST_RESET    = 4'd8,
    ST_FAULT    = 4'd9
  } life_state_t;

  typedef enum logic [3:0] {
    OP_POLL      = 4'd0,
    OP_LONG      = 4'd1,
    OP_VERY_LONG = 4'd2,
    OP_BLE       = 4'd3,
    OP_WIFI      = 4'd4,
    OP_PAIRED    = 4'd5,
    OP_OTA_BEGIN = 4'd6,
    OP_OTA_END   = 4'd7,
    OP_FAULT     = 4'd8,
    OP_INIT      = 4'd9
  } op_t;

  localparam int unsigned FL_PAIRWIN = 0;
  localparam int unsigned FL_BLE     = 1;
  localparam int unsigned FL_WIFI    = 2;
  localparam int unsigned FL_PROV    = 3;
  localparam int unsigned FL_OTA     = 4;

  localparam logic [2:0] LED_SLOW_PULSE  = 3'd0;
  localparam logic [2:0] LED_FAST_BLINK  = 3'd1;
  localparam logic [2:0] LED_DOUBLE      = 3'd2;
  localparam logic [2:0] LED_TRIPLE      = 3'd3;
  localparam logic [2:0] LED_HEARTBEAT   = 3'd4;
  localparam logic [2:0] LED_ERROR_FLASH = 3'd5;

  localparam logic [31:0] DEFAULT_WINDOW_MS = 32'd60000;

  typedef struct packed {
    life_state_t life;
    logic [4:0]  flags;
    logic [31:0] deadline;
    logic [2:0]  led;
  } ctl_state_t;

  function automatic logic [2:0] led_for(input life_state_t s);
    logic [2:0] p;
    begin
      unique case (s)
        ST_PAIRING:  p = LED_FAST_BLINK;
        ST_WIFIPROV: p = LED_DOUBLE;
        ST_LORA:     p = LED_TRIPLE;
        ST_READY:    p = LED_HEARTBEAT;
        ST_OTA:      p = LED_FAST_BLINK;
        ST_RESET:    p = LED_ERROR_FLASH;
        ST_FAULT:    p = LED_ERROR_FLASH;
        default:     p = LED_SLOW_PULSE;
      endcase
      return p;
    end
  endfunction

endpackage

@@ design/device_lifecycle_controller_unit.sv @@
// Device lifecycle controller top level: input register, event decode, result register.
// Depends on dlc_pkg and dlc_step.
//
// One event word is accepted per clock cycle unless a publishing word meets a stalled
// output. An accepted word is held in the input register, where the event decode reads the
// lifecycle state and commits its update; a status word, when the event publishes one,
// goes into the result register when the word leaves the input register; the decode
// between them is combinational. A stalled output holds only words that publish.
module device_lifecycle_controller_unit import dlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_op,
  input  logic        in_flag_value,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_life_state,
  output logic [4:0]  out_status_flags,
  output logic [2:0]  out_led_pattern
);

  logic        s1_vld_r;
  logic [3:0]  s1_op_r;
  logic        s1_flag_r;
  logic [31:0] s1_now_r;
  logic [31:0] window_r;
  ctl_state_t  state_r;
  ctl_state_t  state_nxt;
  logic        pub;
  logic        s1_adv;
  logic        out_vld_r;
  logic [3:0]  out_life_r;
  logic [4:0]  out_flags_r;
  logic [2:0]  out_led_r;

  dlc_step u_step (
    .cur        (state_r),
    .op         (s1_op_r),
    .flag_value (s1_flag_r),
    .now_ms     (s1_now_r),
    .window_ms  (window_r),
    .nxt        (state_nxt),
    .pub        (pub)
  );

  assign s1_adv   = s1_vld_r && (!pub || !out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= DEFAULT_WINDOW_MS;
    end else if (cfg_we) begin
      window_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r   <= in_op;
      s1_flag_r <= in_flag_value;
      s1_now_r  <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.life     <= ST_BOOT;
      state_r.flags    <= '0;
      state_r.deadline <= '0;
      state_r.led      <= LED_SLOW_PULSE;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv && pub) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && pub) begin
      out_life_r  <= state_nxt.life;
      out_flags_r <= state_nxt.flags;
      out_led_r   <= state_nxt.led;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_life_state   = out_life_r;
  assign out_status_flags = out_flags_r;
  assign out_led_pattern  = out_led_r;

endmodule

@@ design/dlc_step.sv @@
// Event decode for the lifecycle controller: next state and publish flag.
// Pure combinational logic; depends on dlc_pkg.
module dlc_step import dlc_pkg::*; (
  input  ctl_state_t  cur,
  input  logic [3:0]  op,
  input  logic        flag_value,
  input  logic [31:0] now_ms,
  input  logic [31:0] window_ms,
  output ctl_state_t  nxt,
  output logic        pub
);

  life_state_t tgt;
  logic        tgt_vld;
  logic        force_pub;

  always_comb begin
    nxt       = cur;
    tgt       = cur.life;
    tgt_vld   = 1'b0;
    force_pub = 1'b0;
    pub       = 1'b0;
    unique case (op)
      OP_POLL: begin
        if (cur.life == ST_BOOT) begin
          tgt     = ST_SELFTEST;
          tgt_vld = 1'b1;
        end else if (cur.life == ST_SELFTEST) begin
          tgt     = ST_UNPROV;
          tgt_vld = 1'b1;
        end else if (cur.life == ST_PAIRING && now_ms >= cur.deadline) begin
          nxt.flags[FL_PAIRWIN] = 1'b0;
          tgt     = ST_UNPROV;
          tgt_vld = 1'b1;
        end
      end
      OP_LONG: begin
        if (cur.life == ST_UNPROV || cur.life == ST_READY) begin
          nxt.deadline          = now_ms + window_ms;
          nxt.flags[FL_PAIRWIN] = 1'b1;
          tgt     = ST_PAIRING;
          tgt_vld = 1'b1;
        end
      end
      OP_VERY_LONG: begin
        tgt     = ST_RESET;
        tgt_vld = 1'b1;
      end
      OP_BLE: begin
        nxt.flags[FL_BLE] = flag_value;
        force_pub         = 1'b1;
      end
      OP_WIFI: begin
        nxt.flags[FL_WIFI] = flag_value;
        if (flag_value && cur.life == ST_WIFIPROV) begin
          tgt     = ST_READY;
          tgt_vld = 1'b1;
        end
        force_pub = 1'b1;
      end
      OP_PAIRED: begin
        nxt.flags[FL_PAIRWIN] = 1'b0;
        nxt.flags[FL_PROV]    = 1'b1;
        tgt     = ST_WIFIPROV;
        tgt_vld = 1'b1;
      end
      OP_OTA_BEGIN: begin
        nxt.flags[FL_OTA] = 1'b1;
        tgt     = ST_OTA;
        tgt_vld = 1'b1;
      end
      OP_OTA_END: begin
        nxt.flags[FL_OTA] = 1'b0;
        tgt     = flag_value ? ST_READY : ST_FAULT;
        tgt_vld = 1'b1;
      end
      OP_FAULT: begin
        tgt     = ST_FAULT;
        tgt_vld = 1'b1;
      end
      OP_INIT: begin
        nxt.life  = ST_BOOT;
        nxt.flags = '0;
        force_pub = 1'b1;
      end
      default: begin
      end
    endcase
    if (tgt_vld && tgt != cur.life) begin
      nxt.life = tgt;
      nxt.led  = led_for(tgt);
      pub      = 1'b1;
    end
    if (force_pub) begin
      pub = 1'b1;
    end
  end

endmodule

@@ tb/dlc_checker.sv @@
`timescale 1ns / 1ps
// Status word checker for device_lifecycle_controller_unit: predicts each status word
// from the accepted event words and the pairing window register, and compares.
// Depends on dlc_pkg.
module dlc_checker import dlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  in_op,
  input  logic        in_flag_value,
  input  logic [31:0] in_now_ms,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_life_state,
  input  logic [4:0]  out_status_flags,
  input  logic [2:0]  out_led_pattern,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    life_state_t life;
    logic [4:0]  flags;
    logic [2:0]  led;
  } status_word_t;

  status_word_t status_q[$];
  logic [31:0]  window_ms;
  life_state_t  life;
  logic [4:0]   flags;
  logic [31:0]  deadline;
  logic [2:0]   led;
  int           errors = 0;

  function automatic logic [2:0] pattern_of(input life_state_t s);
    case (s)
      ST_PAIRING, ST_OTA: return LED_FAST_BLINK;
      ST_WIFIPROV:        return LED_DOUBLE;
      ST_LORA:            return LED_TRIPLE;
      ST_READY:           return LED_HEARTBEAT;
      ST_RESET, ST_FAULT: return LED_ERROR_FLASH;
      default:            return LED_SLOW_PULSE;
    endcase
  endfunction

  task automatic enter_state(input life_state_t nxt, output bit moved);
    moved = (nxt != life);
    if (moved) begin
      life = nxt;
      led = pattern_of(nxt);
    end
  endtask

  task automatic predict_event(input logic [3:0] op, input logic fv, input logic [31:0] now);
    bit publish;
    bit moved;
    publish = 1'b0;
    case (op)
      OP_POLL: begin
        if (life == ST_BOOT) begin
          enter_state(ST_SELFTEST, publish);
        end else if (life == ST_SELFTEST) begin
          enter_state(ST_UNPROV, publish);
        end else if (life == ST_PAIRING && now >= deadline) begin
          flags[FL_PAIRWIN] = 1'b0;
          enter_state(ST_UNPROV, publish);
        end
      end
      OP_LONG: begin
        if (life == ST_UNPROV || life == ST_READY) begin
          deadline = now + window_ms;
          flags[FL_PAIRWIN] = 1'b1;
          enter_state(ST_PAIRING, publish);
        end
      end
      OP_VERY_LONG: enter_state(ST_RESET, publish);
      OP_BLE: begin
        flags[FL_BLE] = fv;
        publish = 1'b1;
      end
      OP_WIFI: begin
        flags[FL_WIFI] = fv;
        if (fv && life == ST_WIFIPROV) enter_state(ST_READY, moved);
        publish = 1'b1;
      end
      OP_PAIRED: begin
        flags[FL_PAIRWIN] = 1'b0;
        flags[FL_PROV] = 1'b1;
        enter_state(ST_WIFIPROV, publish);
      end
      OP_OTA_BEGIN: begin
        flags[FL_OTA] = 1'b1;
        enter_state(ST_OTA, publish);
      end
      OP_OTA_END: begin
        flags[FL_OTA] = 1'b0;
        enter_state(fv ? ST_READY : ST_FAULT, publish);
      end
      OP_FAULT: enter_state(ST_FAULT, publish);
      OP_INIT: begin
        life = ST_BOOT;
        flags = '0;
        publish = 1'b1;
      end
      default: ;
    endcase
    if (publish) status_q.push_back(status_word_t'{life, flags, led});
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    status_word_t want;
    if (!rst_n) begin
      window_ms = DEFAULT_WINDOW_MS;
      life = ST_BOOT;
      flags = '0;
      deadline = '0;
      led = LED_SLOW_PULSE;
      status_q.delete();
    end else begin
      if (cfg_we) window_ms = cfg_wdata;
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          errors++;
          $display("%0t: status word expected none actual life_state %0d status_flags %0d led_pattern %0d",
                   $time, out_life_state, out_status_flags, out_led_pattern);
        end else begin
          want = status_q.pop_front();
          compare_field("life_state", 32'(want.life), 32'(out_life_state));
          compare_field("status_flags", 32'(want.flags), 32'(out_status_flags));
          compare_field("led_pattern", 32'(want.led), 32'(out_led_pattern));
        end
      end
      if (in_valid && in_ready) predict_event(in_op, in_flag_value, in_now_ms);
    end
    pending = status_q.size();
    fail_count = errors;
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for device_lifecycle_controller_unit: drives event words, random
// output stalls and pairing window writes, and gives the verdict. Depends on dlc_pkg
// and dlc_checker.
module tb_top;
  import dlc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_op = '0;
  logic        in_flag_value = 1'b0;
  logic [31:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_life_state;
  logic [4:0]  out_status_flags;
  logic [2:0]  out_led_pattern;
  int          fail_count;
  int          pending;

  int          send_idle_pct = 26;
  int          recv_idle_pct = 67;
  int          words_sent = 0;
  logic [31:0] cur_window = DEFAULT_WINDOW_MS;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  device_lifecycle_controller_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_flag_value    (in_flag_value),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_life_state   (out_life_state),
    .out_status_flags (out_status_flags),
    .out_led_pattern  (out_led_pattern)
  );

  dlc_checker status_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_flag_value    (in_flag_value),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_life_state   (out_life_state),
    .out_status_flags (out_status_flags),
    .out_led_pattern  (out_led_pattern),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  task automatic send_word(input logic [3:0] op, input logic fv, input logic [31:0] now);
    int  gap;
    bit  taken;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_flag_value <= fv;
    in_now_ms <= now;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    if (op <= OP_INIT) words_sent++;
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_window(input logic [31:0] value);
    drain(4);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    cur_window = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_noise();
    send_word(4'($urandom_range(15)), rand_bit(), $urandom);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(99) < 15) send_noise();
  endtask

  task automatic lifecycle_run();
    logic [31:0] base;
    logic [31:0] deadline;
    case ($urandom_range(3))
      0: base = 32'hFFFF_FFFF - $urandom_range(200);
      1: base = $urandom_range(200);
      default: base = $urandom;
    endcase
    deadline = base + cur_window;
    send_word(OP_INIT, rand_bit(), $urandom);
    send_word(OP_POLL, rand_bit(), $urandom);
    send_word(OP_POLL, rand_bit(), $urandom);
    maybe_noise();
    if ($urandom_range(1)) send_word(OP_BLE, rand_bit(), $urandom);
    send_word(OP_LONG, rand_bit(), base);
    repeat ($urandom_range(3)) send_word(OP_POLL, rand_bit(), deadline - 1 - $urandom_range(2));
    if ($urandom_range(2) == 0) begin
      send_word(OP_POLL, rand_bit(), deadline + $urandom_range(1));
      maybe_noise();
      send_word(OP_LONG, rand_bit(), $urandom);
    end else begin
      send_word(OP_PAIRED, rand_bit(), $urandom);
      maybe_noise();
      if ($urandom_range(3) == 0) send_word(OP_WIFI, 1'b0, $urandom);
      send_word(OP_WIFI, 1'b1, $urandom);
      if ($urandom_range(2) == 0) begin
        send_word(OP_LONG, rand_bit(), base);
        send_word(OP_POLL, rand_bit(), deadline + $urandom_range(3) - 1);
        send_word(OP_PAIRED, rand_bit(), $urandom);
        send_word(OP_WIFI, rand_bit(), $urandom);
      end
      maybe_noise();
      send_word(OP_OTA_BEGIN, rand_bit(), $urandom);
      if ($urandom_range(3) == 0) send_word(OP_OTA_BEGIN, rand_bit(), $urandom);
      send_word(OP_OTA_END, rand_bit(), $urandom);
      if ($urandom_range(2) == 0) send_word(OP_FAULT, rand_bit(), $urandom);
      if ($urandom_range(2) == 0) send_word(OP_VERY_LONG, rand_bit(), $urandom);
    end
    maybe_noise();
  endtask

  initial begin
    logic [31:0] windows[6];
    int          target;
    windows = '{32'd0, 32'hFFFF_FFFF, 32'd1, $urandom, 32'd60000, $urandom_range(5000)};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_POLL, 1'b0, 32'd0);
    send_word(OP_POLL, 1'b1, 32'hFFFF_FFFF);
    send_word(OP_POLL, 1'b0, 32'd0);
    send_word(OP_LONG, 1'b1, 32'hFFFF_FFF0);
    send_word(OP_POLL, 1'b0, 32'd59983);
    send_word(OP_POLL, 1'b0, 32'd59984);
    send_word(OP_LONG, 1'b0, 32'd0);
    send_word(OP_POLL, 1'b1, 32'd59999);
    send_word(OP_BLE, 1'b1, 32'd0);
    send_word(OP_PAIRED, 1'b0, 32'd0);
    send_word(OP_WIFI, 1'b0, 32'd0);
    send_word(OP_WIFI, 1'b1, 32'd0);
    send_word(OP_LONG, 1'b1, 32'd100);
    send_word(OP_PAIRED, 1'b1, 32'd0);
    send_word(OP_VERY_LONG, 1'b0, 32'd0);
    send_word(OP_VERY_LONG, 1'b1, 32'd0);
    send_word(OP_OTA_BEGIN, 1'b0, 32'd0);
    send_word(OP_OTA_END, 1'b1, 32'd0);
    send_word(OP_OTA_BEGIN, 1'b1, 32'd0);
    send_word(OP_OTA_END, 1'b0, 32'd0);
    send_word(OP_FAULT, 1'b0, 32'd0);
    send_word(4'd15, 1'b1, 32'hFFFF_FFFF);
    send_word(4'd10, 1'b0, 32'd0);
    send_word(OP_BLE, 1'b0, 32'd0);
    send_word(OP_INIT, 1'b1, 32'd0);

    for (int ph = 0; ph < 6; ph++) begin
      write_window(windows[ph]);
      if (ph < 2) begin
        send_idle_pct = 26;
        recv_idle_pct = 67;
      end else if (ph < 4) begin
        send_idle_pct = 67;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      target = words_sent + 300;
      while (words_sent < target) begin
        if ($urandom_range(4) == 0) begin
          repeat (5) send_noise();
        end else begin
          lifecycle_run();
        end
      end
    end

    drain(8);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
